[rtl/hisc_pkg.sv]
// ----------------------------------------------------------------------------
// hisc_pkg
// Shared types, widths and constants of the homography inlier scorer.
// ----------------------------------------------------------------------------
package hisc_pkg;

    localparam int COEF_W    = 32;
    localparam int CRD_W     = 16;
    localparam int OPD_W     = 17;
    localparam int PROD_W    = COEF_W + OPD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_MAX  = 8;
    localparam int DIV_W     = ACC_W + FRAC_MAX;
    localparam int QUO_W     = 25;
    localparam int QS_W      = QUO_W + 1;
    localparam int DSH_W     = ACC_W + QUO_W;
    localparam int QCNT_W    = $clog2(QUO_W);
    localparam int DX_W      = QS_W + 1;
    localparam int SQ_W      = 2 * DX_W;
    localparam int D2_W      = SQ_W + 1;
    localparam int THR_W     = 16;
    localparam int RES_W     = 17;
    localparam int NCOEF     = 9;
    localparam int IDX_W     = 4;
    localparam int RATIO_SH  = 16;

    localparam logic [QUO_W-1:0] PROJ_LIMIT = QUO_W'(1) << (QUO_W - 1);
    localparam logic [THR_W-1:0] THR_RESET  = THR_W'(160);

    localparam int MAX_POINTS_DEF     = 65536;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int COORD_FRAC_BITS_DEF = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic [CRD_W-1:0]         src_x;
        logic [CRD_W-1:0]         src_y;
        logic [CRD_W-1:0]         dst_x;
        logic [CRD_W-1:0]         dst_y;
        logic                     last;
    } t_req;

    typedef struct packed {
        logic             is_inlier;
        logic [RES_W-1:0] inlier_count;
        logic [RES_W-1:0] point_count;
        logic [RES_W-1:0] ratio_q16;
        logic             batch_done;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DIVX, S_WAITX, S_DIVY, S_WAITY,
        S_SQX, S_SQY, S_SQSUM, S_TALLY, S_DIVR, S_WAITR, S_OUT
    } t_state;

    typedef enum logic [1:0] {DS_X, DS_Y, DS_RATIO} t_div_sel;
    typedef enum logic [1:0] {SQ_NONE, SQ_X, SQ_Y, SQ_SUM} t_sq;

    typedef struct packed {
        logic     capture;
        logic     mac_step;
        logic     div_start;
        t_div_sel div_sel;
        t_sq      sq;
        logic     tally;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_point;
        logic is_last;
        logic mac_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[rtl/hisc_req_if.sv]
// ----------------------------------------------------------------------------
// hisc_req_if
// Request channel: coefficient loads and point pairs.
// ----------------------------------------------------------------------------
interface hisc_req_if import hisc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hisc_res_if.sv]
// ----------------------------------------------------------------------------
// hisc_res_if
// Result channel: one score per point pair.
// ----------------------------------------------------------------------------
interface hisc_res_if import hisc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hisc_cfg_if.sv]
// ----------------------------------------------------------------------------
// hisc_cfg_if
// Configuration write channel for the distance threshold.
// ----------------------------------------------------------------------------
interface hisc_cfg_if import hisc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] dist_threshold;
    modport source (output valid, output dist_threshold, input ready);
    modport sink (input valid, input dist_threshold, output ready);
endinterface

[rtl/homography_inlier_scorer.sv]
// ----------------------------------------------------------------------------
// homography_inlier_scorer
// Scores point pairs against a loaded homography and counts inliers.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Payload
//  i_req    in   valid/ready    t_req: coefficient load or point pair
//  o_res    out  valid/ready    t_res: verdict, tallies, ratio on last pair
//  i_cfg    in   valid/ready    dist_threshold, ready always high
//
//  A coefficient load is taken in the idle state. A point pair runs
//  through the multiply-accumulate and the bit-serial divider, one
//  quotient for x and one for y; the last pair of a batch needs a third
//  quotient for the inlier ratio. One item is worked at a time; a new
//  item is accepted while the previous result still waits in the output register.
//  Reset is synchronous and active low; it restores the identity matrix.
// ----------------------------------------------------------------------------
module homography_inlier_scorer import hisc_pkg::*; #(
    parameter int MAX_POINTS      = MAX_POINTS_DEF,
    parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hisc_req_if.sink   i_req,
    hisc_res_if.source o_res,
    hisc_cfg_if.sink   i_cfg
);
    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    hisc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hisc_dp #(
        .MAX_POINTS      (MAX_POINTS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.dist_threshold),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_res_data  (o_res.data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule

[rtl/hisc_div.sv]
// ----------------------------------------------------------------------------
// hisc_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// quotient saturated to the projection limit.
// ----------------------------------------------------------------------------
module hisc_div import hisc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIV_W-1:0]        i_num,
    input  logic [ACC_W-1:0]        i_den,
    input  logic                    i_neg,
    output logic                    o_done,
    output logic signed [QS_W-1:0]  o_quo
);
    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_q;
    logic              r_sat;
    logic              r_neg;
    logic              ge;
    logic [QUO_W-1:0]  mag;

    assign ge = DSH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= DSH_W'(i_den) << (QUO_W - 1);
            // A quotient of 2^QUO_W or more lies beyond the limit anyway.
            r_sat <= DSH_W'(i_num) >= (DSH_W'(i_den) << QUO_W);
            r_neg <= i_neg;
            r_cnt <= QCNT_W'(QUO_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= DIV_W'(DSH_W'(r_rem) - r_dsh);
            end
            r_q   <= {r_q[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

    assign mag    = (r_sat || r_q > PROJ_LIMIT) ? PROJ_LIMIT : r_q;
    assign o_quo  = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign o_done = r_done;
endmodule

[rtl/hisc_ctrl.sv]
// ----------------------------------------------------------------------------
// hisc_ctrl
// Sequencer of the scorer: takes a coefficient load in idle and steps a point
// pair through projection, division, distance, tally and result.
// ----------------------------------------------------------------------------
module hisc_ctrl import hisc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.div_sel  = DS_X;
        o_cmd.sq       = SQ_NONE;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.in_point) begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_sts.mac_done) begin
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAITX;
            end
            S_WAITX: begin
                if (i_sts.div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_sel   = DS_Y;
                o_cmd.div_start = 1'b1;
                n_state = S_WAITY;
            end
            S_WAITY: begin
                o_cmd.div_sel = DS_Y;
                if (i_sts.div_done) begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.sq = SQ_X;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq = SQ_Y;
                n_state = S_SQSUM;
            end
            S_SQSUM: begin
                o_cmd.sq = SQ_SUM;
                n_state = S_TALLY;
            end
            S_TALLY: begin
                o_cmd.tally = 1'b1;
                n_state = i_sts.is_last ? S_DIVR : S_OUT;
            end
            S_DIVR: begin
                o_cmd.div_sel   = DS_RATIO;
                o_cmd.div_start = 1'b1;
                n_state = S_WAITR;
            end
            S_WAITR: begin
                o_cmd.div_sel = DS_RATIO;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[rtl/hisc_dp.sv]
// ----------------------------------------------------------------------------
// hisc_dp
// Datapath: coefficient registers, shared multiply-accumulate, divider,
// squared distance, saturating tallies and the result register.
// ----------------------------------------------------------------------------
module hisc_dp import hisc_pkg::*; #(
    parameter int MAX_POINTS      = MAX_POINTS_DEF,
    parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req_data,
    input  logic             i_cfg_valid,
    input  logic [THR_W-1:0] i_cfg_data,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output t_res             o_res_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic signed [COEF_W-1:0] r_coef [NCOEF];
    logic [THR_W-1:0]         r_thr;
    t_req                     r_req;
    logic [IDX_W-1:0]         r_mk;
    logic [1:0]               r_col;
    logic [1:0]               r_row;
    logic [1:0]               r_prow;
    logic                     r_pval;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_px;
    logic signed [ACC_W-1:0]  r_py;
    logic signed [ACC_W-1:0]  r_pw;
    logic signed [QS_W-1:0]   r_qx;
    logic signed [QS_W-1:0]   r_qy;
    logic [SQ_W-1:0]          r_sq;
    logic [D2_W-1:0]          r_d2;
    logic [CNT_W-1:0]         r_inl;
    logic [CNT_W-1:0]         r_pair;
    logic                     r_is_inl;
    logic [RES_W-1:0]         r_ratio;
    logic                     r_out_valid;
    t_res                     r_out;

    logic signed [OPD_W-1:0]  op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  num_s;
    logic [ACC_W-1:0]         num_abs;
    logic [ACC_W-1:0]         den_abs;
    logic [DIV_W-1:0]         div_num;
    logic [ACC_W-1:0]         div_den;
    logic                     div_neg;
    logic                     div_done;
    logic signed [QS_W-1:0]   div_quo;
    logic signed [DX_W-1:0]   dx;
    logic signed [DX_W-1:0]   dy;
    logic signed [SQ_W-1:0]   sq_x;
    logic signed [SQ_W-1:0]   sq_y;
    logic [2*THR_W-1:0]       thr2;
    logic                     inl;
    logic                     mac_last;

    always_comb begin
        case (r_col)
            2'd0:    op = $signed(OPD_W'(r_req.src_x));
            2'd1:    op = $signed(OPD_W'(r_req.src_y));
            default: op = $signed(OPD_W'(1) << COORD_FRAC_BITS);
        endcase
    end

    assign prod     = r_coef[r_mk] * op;
    assign mac_last = (r_mk == IDX_W'(NCOEF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[0] <= COEF_W'(1) << COEF_FRAC_BITS;
            r_coef[4] <= COEF_W'(1) << COEF_FRAC_BITS;
            r_coef[8] <= COEF_W'(1) << COEF_FRAC_BITS;
            r_thr     <= THR_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.capture && i_req_data.req_type == REQ_LOAD &&
                i_req_data.coef_index < IDX_W'(NCOEF)) begin
                r_coef[i_req_data.coef_index] <= i_req_data.coef_value;
            end
        end
    end

    // Nine products go through one multiplier; each is registered and added in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_data;
            r_mk   <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_pval <= 1'b0;
            r_px   <= '0;
            r_py   <= '0;
            r_pw   <= '0;
        end else if (i_cmd.mac_step) begin
            r_pval <= !mac_last;
            if (!mac_last) begin
                r_prod <= prod;
                r_prow <= r_row;
                r_mk   <= r_mk + IDX_W'(1);
                if (r_col == 2'd2) begin
                    r_col <= '0;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
            if (r_pval) begin
                case (r_prow)
                    2'd0:    r_px <= r_px + ACC_W'(r_prod);
                    2'd1:    r_py <= r_py + ACC_W'(r_prod);
                    default: r_pw <= r_pw + ACC_W'(r_prod);
                endcase
            end
        end
    end

    always_comb begin
        num_s   = (i_cmd.div_sel == DS_Y) ? r_py : r_px;
        num_abs = num_s[ACC_W-1] ? ACC_W'(-num_s) : ACC_W'(num_s);
        den_abs = r_pw[ACC_W-1] ? ACC_W'(-r_pw) : ACC_W'(r_pw);
        if (i_cmd.div_sel == DS_RATIO) begin
            div_num = DIV_W'({r_inl, RATIO_SH'(0)});
            div_den = ACC_W'(r_pair);
            div_neg = 1'b0;
        end else begin
            div_num = DIV_W'(num_abs) << COORD_FRAC_BITS;
            div_den = den_abs;
            div_neg = num_s[ACC_W-1] ^ r_pw[ACC_W-1];
        end
    end

    hisc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign dx   = DX_W'(r_qx) - $signed(DX_W'(r_req.dst_x));
    assign dy   = DX_W'(r_qy) - $signed(DX_W'(r_req.dst_y));
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign thr2 = r_thr * r_thr;
    assign inl  = (r_pw != '0) && (r_d2 < D2_W'(thr2));

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.div_sel)
                DS_X:     r_qx    <= div_quo;
                DS_Y:     r_qy    <= div_quo;
                default:  r_ratio <= RES_W'(div_quo);
            endcase
        end
        case (i_cmd.sq)
            SQ_X: begin
                r_sq <= SQ_W'(sq_x);
            end
            SQ_Y: begin
                r_d2 <= D2_W'(r_sq);
                r_sq <= SQ_W'(sq_y);
            end
            SQ_SUM: begin
                r_d2 <= r_d2 + D2_W'(r_sq);
            end
            default: begin
            end
        endcase
        if (i_cmd.tally) begin
            r_is_inl <= inl;
        end
        if (i_cmd.out_load) begin
            r_out.is_inlier    <= r_is_inl;
            r_out.inlier_count <= RES_W'(r_inl);
            r_out.point_count  <= RES_W'(r_pair);
            r_out.ratio_q16    <= r_req.last ? r_ratio : '0;
            r_out.batch_done   <= r_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inl       <= '0;
            r_pair      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tally) begin
                r_pair <= (r_pair >= CNT_MAX) ? CNT_MAX : r_pair + CNT_W'(1);
                if (inl) begin
                    r_inl <= (r_inl >= CNT_MAX) ? CNT_MAX : r_inl + CNT_W'(1);
                end
            end
            if (i_cmd.out_load && r_req.last) begin
                r_inl  <= '0;
                r_pair <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_res_data      = r_out;
    assign o_sts.in_point  = (i_req_data.req_type == REQ_POINT);
    assign o_sts.is_last   = r_req.last;
    assign o_sts.mac_done  = i_cmd.mac_step && mac_last;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_res_ready;
endmodule

[rtl/hisc_chk.sv]
// ----------------------------------------------------------------------------
// hisc_chk
// Port-level checks on the result channel of the scorer.
// ----------------------------------------------------------------------------
module hisc_chk import hisc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    a_ratio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.batch_done |-> i_res_data.ratio_q16 == '0)
        else $error("ratio shown before the last pair");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_data.inlier_count <= i_res_data.point_count)
        else $error("more inliers than pairs");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_data.ratio_q16 <= RES_W'(65536))
        else $error("ratio above one");

    a_inlier_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.is_inlier |-> i_res_data.inlier_count != '0)
        else $error("inlier without count");
endmodule

bind homography_inlier_scorer hisc_chk u_hisc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
